FILE: hdl/hgrnp_pkg.sv
// Shared types, codes and character tables for the GET request name parser.
// Used by every module of the block but hgrnp_ram; depends on nothing.
package hgrnp_pkg;

  localparam logic [1:0] PH_WAIT_GET = 2'd0;
  localparam logic [1:0] PH_COLLECT  = 2'd1;
  localparam logic [1:0] PH_WAIT_END = 2'd2;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_SERVE     = 2'd1;
  localparam logic [1:0] EV_NOT_FOUND = 2'd2;
  localparam logic [1:0] EV_IGNORED   = 2'd3;

  localparam int SUFFIX_LEN = 9;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] name_start;
    logic [7:0] name_length;
    logic [7:0] read_byte;
  } out_beat_t;

  typedef struct packed {
    logic scan_start;
    logic scan_active;
    logic store_wr;
    logic count_clr;
    logic rd_issue;
    logic load_none;
    logic load_read;
    logic load_finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic count_full;
    logic scan_done;
  } dp_stat_t;

  function automatic logic [7:0] get_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = "G";
      2'd1: c = "E";
      2'd2: c = "T";
      default: c = " ";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] end_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = CH_CR;
      2'd1: c = CH_LF;
      2'd2: c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] suffix_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = " ";
      4'd1: c = "H";
      4'd2: c = "T";
      4'd3: c = "T";
      4'd4: c = "P";
      4'd5: c = "/";
      4'd6: c = "1";
      4'd7: c = ".";
      4'd8: c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == "/") || (c == 8'h5C) || (c == ":");
  endfunction

  function automatic logic name_char_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_") || (c == ".");
  endfunction

endpackage

FILE: hdl/hgrnp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the stored URL bytes of the parser.
module hgrnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/hgrnp_ctrl.sv
// Controller of the parser: request phase tracking, keyword matching and
// the sequencer for reads and the end-of-request scan. Uses hgrnp_pkg.
module hgrnp_ctrl import hgrnp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_beat_t in_data,
  input  logic     out_stall,
  output logic     in_stall,
  output logic     out_valid,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] match_r, match_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [1:0] parse_ph;
  logic [1:0] parse_mc;
  logic       parse_wr;
  logic       parse_drop;
  logic       parse_fin;
  logic       accept;
  logic [7:0] b;

  assign b         = in_data.data_byte;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    parse_ph   = phase_r;
    parse_mc   = match_r;
    parse_wr   = 1'b0;
    parse_drop = 1'b0;
    parse_fin  = 1'b0;
    if (parse_ph == PH_COLLECT) begin
      if (b == CH_CR || b == CH_LF) begin
        parse_ph = PH_WAIT_END;
      end else if (b >= PRINT_LO && b <= PRINT_HI && !stat.count_full) begin
        parse_wr = 1'b1;
      end else begin
        parse_ph   = PH_WAIT_GET;
        parse_mc   = 2'd0;
        parse_drop = 1'b1;
      end
    end else if (parse_ph != PH_WAIT_END) begin
      if (b == get_char(parse_mc)) begin
        if (parse_mc == 2'd3) begin
          parse_ph = PH_COLLECT;
          parse_mc = 2'd0;
        end else begin
          parse_mc = parse_mc + 2'd1;
        end
      end else begin
        parse_mc = 2'd0;
      end
    end
    if (parse_ph == PH_COLLECT || parse_ph == PH_WAIT_END) begin
      if (b == end_char(parse_mc)) begin
        if (parse_mc == 2'd3) begin
          parse_ph  = PH_WAIT_GET;
          parse_mc  = 2'd0;
          parse_fin = 1'b1;
        end else begin
          parse_mc = parse_mc + 2'd1;
        end
      end else begin
        parse_mc = 2'd0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            phase_nxt     = parse_ph;
            match_nxt     = parse_mc;
            cmd.store_wr  = parse_wr;
            cmd.count_clr = parse_drop;
            if (parse_fin) begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end else begin
              cmd.load_none = 1'b1;
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_active = 1'b1;
        if (stat.scan_done) begin
          cmd.load_finish = 1'b1;
          cmd.count_clr   = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WAIT_GET;
      match_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/hgrnp_dp.sv
// Datapath of the parser: URL store, byte count, name scan and result register.
// Uses hgrnp_pkg and hgrnp_ram; driven by commands from hgrnp_ctrl.
module hgrnp_dp import hgrnp_pkg::*; #(
  parameter int MAX_URL_BYTES = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output out_beat_t out_data
);

  localparam int CW = $clog2(MAX_URL_BYTES + 1);
  localparam int AW = $clog2(MAX_URL_BYTES);
  localparam int IW = (CW > 8) ? CW : 8;

  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_i_r;
  logic [CW-1:0] rd_pos_r;
  logic [CW-1:0] first_r;
  logic          rd_vld_r;
  logic          bad_r;
  logic          suf_bad_r;
  logic          idx_ok_r;
  out_beat_t     out_r;

  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_q;
  logic          short_url;
  logic [CW-1:0] body;
  logic          in_suffix;
  logic [3:0]    suf_idx;
  logic          scan_more;
  logic [CW-1:0] name_len;
  out_beat_t     fin_beat;

  assign ram_raddr = cmd.scan_active ? AW'(scan_i_r) : AW'(in_data.read_index);

  hgrnp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_URL_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store_wr),
    .waddr (AW'(count_r)),
    .wdata (in_data.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign short_url = count_r < CW'(SUFFIX_LEN);
  assign body      = count_r - CW'(SUFFIX_LEN);
  assign in_suffix = rd_pos_r >= body;
  assign suf_idx   = 4'(rd_pos_r - body);
  assign scan_more = scan_i_r != count_r;
  assign name_len  = body - first_r;

  assign stat.scan_done  = !scan_more && !rd_vld_r;
  assign stat.count_full = count_r == CW'(MAX_URL_BYTES);

  always_comb begin
    fin_beat = '0;
    if (short_url || suf_bad_r) begin
      fin_beat.event_res = EV_IGNORED;
    end else if (first_r >= body) begin
      fin_beat.event_res  = EV_NOT_FOUND;
      fin_beat.name_start = 8'(first_r);
    end else begin
      fin_beat.event_res   = bad_r ? EV_NOT_FOUND : EV_SERVE;
      fin_beat.name_start  = 8'(first_r);
      fin_beat.name_length = 8'(name_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.count_clr) begin
        count_r <= '0;
      end else if (cmd.store_wr) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.scan_start) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_active) begin
        rd_vld_r <= scan_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i_r  <= '0;
      first_r   <= '0;
      bad_r     <= 1'b0;
      suf_bad_r <= 1'b0;
    end else if (cmd.scan_active) begin
      if (scan_more) begin
        scan_i_r <= scan_i_r + CW'(1);
      end
      rd_pos_r <= scan_i_r;
      if (rd_vld_r && !short_url) begin
        if (in_suffix) begin
          if (ram_q != suffix_char(suf_idx)) begin
            suf_bad_r <= 1'b1;
          end
        end else if (is_sep(ram_q)) begin
          first_r <= rd_pos_r + CW'(1);
          bad_r   <= 1'b0;
        end else if (!name_char_ok(ram_q)) begin
          bad_r <= 1'b1;
        end
      end
    end
    if (cmd.rd_issue) begin
      idx_ok_r <= IW'(in_data.read_index) < IW'(MAX_URL_BYTES);
    end
    if (cmd.load_none) begin
      out_r <= '0;
    end else if (cmd.load_read) begin
      out_r <= '{event_res: EV_NONE, name_start: 8'd0, name_length: 8'd0,
                 read_byte: (idx_ok_r ? ram_q : 8'h00)};
    end else if (cmd.load_finish) begin
      out_r <= fin_beat;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/http_get_request_name_parser.sv
// Top level of the HTTP GET request name parser.
// Joins hgrnp_ctrl and hgrnp_dp; types from hgrnp_pkg.
//
// Usage: the input channel carries one beat per request byte (func 0) or
// per read of a stored URL byte (func 1). Every input beat yields exactly
// one output beat. A byte beat reports event none, except the final LF of
// the blank line that ends the headers, which reports serve, not found or
// ignored with the position and length of the file name in the store.
// A read beat returns the stored byte at read_index.
// Timing: the result of a byte beat other than the last of a request is
// registered and appears in the next cycle, so bytes stream at one per
// cycle while the output drains. A read beat passes through the
// registered read of the store and then the result register, and the
// input stalls meanwhile. For the final byte of a request, the name scan
// walks the stored URL through the single read port, one byte per cycle.
// Reset clears the phase, match count and byte count; the store itself is
// not cleared. While the receiver stalls, the result is held and a new
// input beat is taken only in the cycle in which the held result leaves.
module http_get_request_name_parser import hgrnp_pkg::*; #(
  parameter int MAX_URL_BYTES = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  hgrnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  hgrnp_dp #(
    .MAX_URL_BYTES (MAX_URL_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: hdl/hgrnp_chk.sv
// Port-level checker for the GET request name parser, bound to the top level.
// Uses hgrnp_pkg for the beat types and event codes.
module hgrnp_chk import hgrnp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func |=> in_stall)
    else $error("input taken during store read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func |-> ##2
      (out_valid && out_data.event_res == EV_NONE &&
       out_data.name_start == 8'd0 && out_data.name_length == 8'd0))
    else $error("read beat gave a malformed result");

  a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.func && in_data.data_byte != CH_LF |=>
      (out_valid && out_data.event_res == EV_NONE && out_data.read_byte == 8'd0))
    else $error("byte beat without request end gave an event");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == EV_IGNORED |->
      out_data.name_start == 8'd0 && out_data.name_length == 8'd0)
    else $error("ignored request reported a name");

endmodule

bind http_get_request_name_parser hgrnp_chk u_chk (.*);

FILE: test/tb_http_get_request_name_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for http_get_request_name_parser: directed and random request
// streams with random idling on both sides, scored against a behavioral parser model.
// Depends on hgrnp_pkg and the RTL under hdl only.
module tb_http_get_request_name_parser import hgrnp_pkg::*;;

  localparam int URL_DEPTH = 255;
  localparam int RANDOM_BEATS = 900;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    string      text;
    logic       func;
    logic [7:0] val;
    logic       typed;
    out_beat_t  want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  string get_word = "GET ";
  string crlf_word = "\015\012\015\012";
  string http_tail = " HTTP/1.1";
  string name_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";

  logic [1:0]  phase;
  int          match_cnt;
  logic [7:0]  url_mem [URL_DEPTH];
  int          url_len;
  int          store_hi;

  out_beat_t   pending_results [$];
  logic [7:0]  req_q [$];
  row_t        dir_rows [$];
  int          fault_count = 0;
  int          results_seen = 0;
  int          bytes_fed = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  http_get_request_name_parser #(.MAX_URL_BYTES(URL_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic out_beat_t mk(logic [1:0] ev, logic [7:0] start, logic [7:0] len);
    out_beat_t r;
    r = '0;
    r.event_res = ev;
    r.name_start = start;
    r.name_length = len;
    return r;
  endfunction

  function automatic logic is_name_byte(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2E;
  endfunction

  function automatic out_beat_t judge_request();
    out_beat_t r;
    int i;
    int body;
    int first;
    r = mk(EV_IGNORED, 8'd0, 8'd0);
    if (url_len < SUFFIX_LEN) return r;
    for (i = 0; i < SUFFIX_LEN; i++) begin
      if (url_mem[url_len - SUFFIX_LEN + i] != http_tail[i]) return r;
    end
    body = url_len - SUFFIX_LEN;
    first = 0;
    for (i = body; i > 0; i--) begin
      if (url_mem[i-1] == "/" || url_mem[i-1] == 8'h5C || url_mem[i-1] == ":") begin
        first = i;
        break;
      end
    end
    r = mk(EV_NOT_FOUND, first[7:0], 8'd0);
    if (first >= body) return r;
    r.name_length = 8'(body - first);
    for (i = first; i < body; i++) begin
      if (!is_name_byte(url_mem[i])) return r;
    end
    r.event_res = EV_SERVE;
    return r;
  endfunction

  function automatic out_beat_t parse_beat(in_beat_t b);
    out_beat_t r;
    logic [7:0] c;
    r = '0;
    c = b.data_byte;
    if (b.func) begin
      if (b.read_index < URL_DEPTH) r.read_byte = url_mem[b.read_index];
      return r;
    end
    if (phase == PH_COLLECT) begin
      if (c == CH_CR || c == CH_LF) begin
        phase = PH_WAIT_END;
      end else if (c >= PRINT_LO && c <= PRINT_HI && url_len < URL_DEPTH) begin
        url_mem[url_len] = c;
        url_len++;
        if (url_len > store_hi) store_hi = url_len;
      end else begin
        phase = PH_WAIT_GET;
        match_cnt = 0;
        url_len = 0;
      end
    end else if (phase != PH_WAIT_END) begin
      if (c == get_word[match_cnt & 3]) begin
        match_cnt++;
        if (match_cnt >= 4) begin
          phase = PH_COLLECT;
          match_cnt = 0;
        end
      end else begin
        match_cnt = 0;
      end
    end
    if (phase == PH_COLLECT || phase == PH_WAIT_END) begin
      if (c == crlf_word[match_cnt & 3]) begin
        match_cnt++;
        if (match_cnt >= 4) begin
          phase = PH_WAIT_GET;
          match_cnt = 0;
          r = judge_request();
          url_len = 0;
        end
      end else begin
        match_cnt = 0;
      end
    end
    return r;
  endfunction

  task automatic report(string msg);
    if (fault_count < 100) $display("mismatch: %s", msg);
    fault_count++;
  endtask

  task automatic check_result(out_beat_t got);
    out_beat_t w;
    if (pending_results.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      w = pending_results.pop_front();
      if (got.event_res !== w.event_res)
        report($sformatf("result %0d event_res %0d, expected %0d", results_seen,
                         got.event_res, w.event_res));
      if (got.name_start !== w.name_start)
        report($sformatf("result %0d name_start %0d, expected %0d", results_seen,
                         got.name_start, w.name_start));
      if (got.name_length !== w.name_length)
        report($sformatf("result %0d name_length %0d, expected %0d", results_seen,
                         got.name_length, w.name_length));
      if (got.read_byte !== w.read_byte)
        report($sformatf("result %0d read_byte %0d, expected %0d", results_seen,
                         got.read_byte, w.read_byte));
    end
    results_seen++;
  endtask

  task automatic put_beat(in_beat_t b, logic typed, out_beat_t want);
    int gap;
    out_beat_t got;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = parse_beat(b);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic put_byte(logic [7:0] c, logic typed, out_beat_t want);
    in_beat_t b;
    b.func = 1'b0;
    b.data_byte = c;
    b.read_index = 8'($urandom);
    put_beat(b, typed, want);
  endtask

  task automatic put_read(logic [7:0] idx);
    in_beat_t b;
    b.func = 1'b1;
    b.data_byte = 8'($urandom);
    b.read_index = idx;
    put_beat(b, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_read_index();
    if (store_hi == 0 || $urandom_range(0, 7) == 0) return 8'd255;
    return 8'($urandom_range(0, store_hi - 1));
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic add_row(string text, logic func, logic [7:0] val, logic typed,
                         out_beat_t want);
    row_t r;
    r.text = text;
    r.func = func;
    r.val = val;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] url_char();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      r = $urandom_range(0, 2);
      return (r == 0) ? 8'h2F : (r == 1) ? 8'h5C : 8'h3A;
    end
    if (r == 1) return 8'($urandom_range(32, 126));
    return name_set[$urandom_range(0, name_set.len() - 1)];
  endfunction

  function automatic logic [7:0] bad_byte();
    int c;
    c = $urandom_range(0, 160);
    if (c > 31) c += 95;
    return 8'(c);
  endfunction

  task automatic make_request(int forced);
    int body;
    int kind;
    int i;
    req_q.delete();
    kind = $urandom_range(0, 19);
    if (forced >= 0 || kind < 17) begin
      push_text("GET ");
    end else if (kind == 17) begin
      push_text("GGET ");
    end else if (kind == 18) begin
      push_text("GEt ");
    end else begin
      repeat ($urandom_range(1, 4)) req_q.push_back(8'($urandom));
      push_text("GET ");
    end
    if (forced >= 0) body = forced - SUFFIX_LEN;
    else if ($urandom_range(0, 29) == 0) body = $urandom_range(190, 250);
    else body = $urandom_range(0, 16);
    for (i = 0; i < body; i++) req_q.push_back(url_char());
    kind = $urandom_range(0, 9);
    if (forced >= 0 || kind < 8) begin
      push_text(http_tail);
    end else if (kind == 8) begin
      push_text(http_tail);
      req_q[req_q.size() - 1 - $urandom_range(0, 8)] = 8'($urandom_range(32, 126));
    end
    if (forced < 0 && $urandom_range(0, 14) == 0)
      req_q[$urandom_range(4, req_q.size() - 1)] = bad_byte();
    kind = $urandom_range(0, 19);
    if (forced < 0 && kind == 0) begin
      return;
    end else if (forced < 0 && kind < 4) begin
      push_text("\012");
      push_text(crlf_word);
    end else begin
      push_text("\015\012");
      repeat ($urandom_range(0, 2)) begin
        push_text("Host: ");
        repeat ($urandom_range(1, 8)) req_q.push_back(8'($urandom_range(32, 126)));
        push_text("\015\012");
      end
      push_text("\015\012");
    end
  endtask

  task automatic feed_request(bit count_it);
    int i;
    for (i = 0; i < req_q.size(); i++) begin
      if ($urandom_range(0, 11) == 0) begin
        put_read(pick_read_index());
        if (count_it) bytes_fed++;
      end
      put_byte(req_q[i], 1'b0, '0);
      if (count_it) bytes_fed++;
    end
  endtask

  initial begin
    int k;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      k = rx_calm ? 0 : $urandom_range(0, 12);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
    end
  end

  initial begin
    int i;
    int last;
    phase = PH_WAIT_GET;
    match_cnt = 0;
    url_len = 0;
    store_hi = 0;

    add_row("", 1'b1, 8'd255, 1'b1, mk(EV_NONE, 8'd0, 8'd0));
    add_row("", 1'b0, 8'h00, 1'b1, mk(EV_NONE, 8'd0, 8'd0));
    add_row("", 1'b0, 8'hFF, 1'b1, mk(EV_NONE, 8'd0, 8'd0));
    add_row("GET \015\012\015\012", 1'b0, 8'd0, 1'b1, mk(EV_IGNORED, 8'd0, 8'd0));
    add_row("GGET /a HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b0, '0);
    add_row("GET /dir/file_1.txt HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_SERVE, 8'd5, 8'd10));
    add_row("", 1'b1, 8'd5, 1'b0, '0);
    add_row("", 1'b1, 8'd0, 1'b0, '0);
    add_row("GET /x/ HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_NOT_FOUND, 8'd3, 8'd0));
    add_row("GET c:\\a-b HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_NOT_FOUND, 8'd3, 8'd3));
    add_row("GET /a HTTP/1.0\015\012\015\012", 1'b0, 8'd0, 1'b1, mk(EV_IGNORED, 8'd0, 8'd0));
    add_row("GET /a\001b HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b0, '0);
    add_row("GET ~\177\015\012\015\012", 1'b0, 8'd0, 1'b0, '0);
    add_row("GET /a\012X\015\012\015\012", 1'b0, 8'd0, 1'b0, '0);
    add_row("GET noslash HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_SERVE, 8'd0, 8'd7));
    add_row("GET  ~ HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_NOT_FOUND, 8'd0, 8'd2));
    add_row("GET  HTTP/1.1\015\012\015\012", 1'b0, 8'd0, 1'b1,
            mk(EV_NOT_FOUND, 8'd0, 8'd0));
    add_row("", 1'b1, 8'd2, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].text.len() == 0) begin
        if (dir_rows[r].func) begin
          put_beat('{func: 1'b1, data_byte: 8'h00, read_index: dir_rows[r].val},
                   dir_rows[r].typed, dir_rows[r].want);
        end else begin
          put_byte(dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
        end
      end else begin
        last = dir_rows[r].text.len() - 1;
        for (i = 0; i <= last; i++)
          put_byte(dir_rows[r].text[i], dir_rows[r].typed && i == last, dir_rows[r].want);
      end
    end
    drain_results();

    make_request(URL_DEPTH);
    feed_request(1'b0);
    put_read(8'd254);
    put_read(8'd128);
    make_request(URL_DEPTH + 1);
    feed_request(1'b0);
    put_read(8'd254);

    while (bytes_fed < RANDOM_BEATS) begin
      if ($urandom_range(0, 4) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 3) == 0) begin
        req_q.delete();
        repeat ($urandom_range(1, 6)) req_q.push_back(8'($urandom));
      end else begin
        make_request(-1);
      end
      feed_request(1'b1);
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
